// ----- design/mesh_vertex_normal_averager_defines.svh -----
// Assertion macros shared by the mesh vertex normal averager checkers.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef MESH_VERTEX_NORMAL_AVERAGER_DEFINES_SVH
`define MESH_VERTEX_NORMAL_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MVA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define MVA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mva_pkg.sv -----
// Shared types and constants of the mesh vertex normal averager.
// Used by the datapath, the controller and the top level; depends on nothing.
package mva_pkg;

	localparam int VERTEX_DEPTH_DEF = 1024;

	// Field and internal widths
	localparam int IDX_W  = 10;
	localparam int POS_W  = 18;
	localparam int DIFF_W = POS_W + 1;
	localparam int CR_W   = 2 * DIFF_W + 1;
	localparam int MAG_W  = CR_W - 1;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 8;
	localparam int N_W    = 16;
	localparam int NRM_W  = 30;
	localparam int SQ_W   = 62;
	localparam int LEN_W  = 31;
	localparam int Q_W    = 15;
	localparam int NUM_W  = 46;
	localparam int REC_W  = 3 * SUM_W + CNT_W;

	// Iteration counts of the shared normalize unit
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int DIV_STEPS  = Q_W;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_TRI  = 2'd1,
		MODE_READ = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_LOAD_WR,
		OP_POS_RD,
		OP_DIFF,
		OP_MUL,
		OP_NINIT,
		OP_SHIFT,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_STORE,
		OP_SUM_RD,
		OP_SUM_WR,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_LOAD,
		ST_POSRD,
		ST_POSW,
		ST_DIFF,
		ST_MUL,
		ST_NINIT,
		ST_NCHK,
		ST_NSHIFT,
		ST_SQ,
		ST_SQI,
		ST_SQRT,
		ST_DINIT,
		ST_DSTEP,
		ST_DSTORE,
		ST_SUMRD,
		ST_SUMWR,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  vi_ok;
		logic  tri_ok;
		logic  nz;
		logic  big;
	} dp_stat_t;

endpackage

// ----- design/mesh_vertex_normal_averager.sv -----
// Top level of the mesh vertex normal averager: controller plus datapath.
// Depends on mva_pkg, mva_ctrl, mva_datapath (and through it mva_ram).
//
// One request at a time. A triangle (mode 1) whose cross product is too wide
// is first scaled down one bit per shift, by up to 8 bits; a degenerate
// triangle skips the square root and the divisions. A normal read (mode 2)
// never needs scaling (a stored sum is narrow enough) and skips them too for
// an unused vertex, a cancelled sum or an index beyond the depth. A read
// result waits until the output register is free. A load or triangle with an
// index beyond the depth, and mode 3, return to idle without further work.
// The shared normalize unit runs a 31-step square root and three 15-step
// divisions; each of the two memories has a single read and a single write port.
// A new request is taken while a finished result still waits at the output.
// Position and sum memories hold no reset state; read only loaded vertices.
module mesh_vertex_normal_averager #(
	parameter int VERTEX_DEPTH = mva_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic [mva_pkg::IDX_W-1:0]        vertex_index,
	input  logic signed [mva_pkg::POS_W-1:0] pos_x,
	input  logic signed [mva_pkg::POS_W-1:0] pos_y,
	input  logic signed [mva_pkg::POS_W-1:0] pos_z,
	input  logic [mva_pkg::IDX_W-1:0]        corner_a,
	input  logic [mva_pkg::IDX_W-1:0]        corner_b,
	input  logic [mva_pkg::IDX_W-1:0]        corner_c,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [mva_pkg::N_W-1:0]   normal_x,
	output logic signed [mva_pkg::N_W-1:0]   normal_y,
	output logic signed [mva_pkg::N_W-1:0]   normal_z,
	output logic                             unused_vertex
);

	mva_pkg::dp_cmd_t  cmd;
	mva_pkg::dp_stat_t stat;

	mva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	mva_datapath #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.vertex_index  (vertex_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.cmd           (cmd),
		.stat          (stat),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.unused_vertex (unused_vertex)
	);

endmodule

// ----- design/mva_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/mva_datapath.sv -----
// Datapath: position and sum memories, cross product, shared normalize unit
// (square root and divider), saturating accumulate and output register.
// Depends on mva_pkg and mva_ram.
module mva_datapath #(
	parameter int VERTEX_DEPTH = mva_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         mode,
	input  logic [mva_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [mva_pkg::POS_W-1:0]   pos_x,
	input  logic signed [mva_pkg::POS_W-1:0]   pos_y,
	input  logic signed [mva_pkg::POS_W-1:0]   pos_z,
	input  logic [mva_pkg::IDX_W-1:0]          corner_a,
	input  logic [mva_pkg::IDX_W-1:0]          corner_b,
	input  logic [mva_pkg::IDX_W-1:0]          corner_c,
	input  mva_pkg::dp_cmd_t                   cmd,
	output mva_pkg::dp_stat_t                  stat,
	output logic signed [mva_pkg::N_W-1:0]     normal_x,
	output logic signed [mva_pkg::N_W-1:0]     normal_y,
	output logic signed [mva_pkg::N_W-1:0]     normal_z,
	output logic                               unused_vertex
);

	localparam int AW    = $clog2(VERTEX_DEPTH);
	localparam int POS3W = 3 * mva_pkg::POS_W;
	localparam int PROD_W = 2 * mva_pkg::DIFF_W;

	// latched request
	mva_pkg::mode_t                  mode_q;
	logic [mva_pkg::IDX_W-1:0]       vi_q, ca_q, cb_q, cc_q;
	logic [mva_pkg::POS_W-1:0]       px_q, py_q, pz_q;

	// triangle corner positions and edge vectors
	logic                            rd_pend_q;
	logic [1:0]                      rd_sel_q;
	logic [POS3W-1:0]                pos_q [3];
	logic signed [mva_pkg::DIFF_W-1:0] u_q [3];
	logic signed [mva_pkg::DIFF_W-1:0] w_q [3];
	logic signed [mva_pkg::CR_W-1:0]   cr_q [3];

	// normalize unit
	logic [mva_pkg::MAG_W-1:0]       mag_q [3];
	logic                            neg_q [3];
	logic [mva_pkg::SQ_W-1:0]        acc_q, x_q, res_q, bit_q;
	logic [mva_pkg::NUM_W-1:0]       rem_q, dsh_q;
	logic [mva_pkg::Q_W-1:0]         quo_q;
	logic signed [mva_pkg::N_W-1:0]  n_q [3];
	logic                            unused_q;

	// output register
	logic signed [mva_pkg::N_W-1:0]  out_x_q, out_y_q, out_z_q;
	logic                            out_unused_q;

	// memory ports
	logic                            pos_we, sum_we;
	logic [AW-1:0]                   pos_raddr, sum_raddr, sum_waddr;
	logic [POS3W-1:0]                pos_rdata;
	logic [mva_pkg::REC_W-1:0]       sum_rdata, sum_wdata;

	// combinational helpers
	logic [mva_pkg::IDX_W-1:0]       corner_sel;
	logic signed [mva_pkg::DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]        prod;
	logic [mva_pkg::MAG_W-1:0]       mag_sel;
	logic                            neg_sel;
	logic [2*mva_pkg::NRM_W-1:0]     sq;
	logic [mva_pkg::SQ_W-1:0]        sq_try;
	logic                            cnt_zero;
	logic signed [mva_pkg::CR_W-1:0] vec [3];
	logic [mva_pkg::CNT_W-1:0]       cnt_rd;

	// saturating add of a Q1.14 component to a 24-bit sum
	function automatic logic [mva_pkg::SUM_W-1:0] sat_add(
		input logic [mva_pkg::SUM_W-1:0] a,
		input logic signed [mva_pkg::N_W-1:0] b
	);
		logic signed [mva_pkg::SUM_W:0] s;
		s = (mva_pkg::SUM_W+1)'(signed'(a)) + (mva_pkg::SUM_W+1)'(b);
		if (s[mva_pkg::SUM_W] != s[mva_pkg::SUM_W-1]) begin
			sat_add = s[mva_pkg::SUM_W] ? {1'b1, {(mva_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(mva_pkg::SUM_W-1){1'b1}}};
		end else begin
			sat_add = s[mva_pkg::SUM_W-1:0];
		end
	endfunction

	// status back to the controller
	always_comb begin
		stat.mode   = mode_q;
		stat.vi_ok  = 32'(vi_q) < VERTEX_DEPTH;
		stat.tri_ok = (32'(ca_q) < VERTEX_DEPTH) && (32'(cb_q) < VERTEX_DEPTH)
			&& (32'(cc_q) < VERTEX_DEPTH);
		stat.nz     = (mag_q[0] != '0) || (mag_q[1] != '0) || (mag_q[2] != '0);
		stat.big    = (|mag_q[0][mva_pkg::MAG_W-1:mva_pkg::NRM_W])
			|| (|mag_q[1][mva_pkg::MAG_W-1:mva_pkg::NRM_W])
			|| (|mag_q[2][mva_pkg::MAG_W-1:mva_pkg::NRM_W]);
	end

	// corner chosen by the command
	always_comb begin
		case (cmd.sel[1:0])
			2'd0:    corner_sel = ca_q;
			2'd1:    corner_sel = cb_q;
			default: corner_sel = cc_q;
		endcase
	end

	// memory addressing
	assign pos_we    = cmd.op == mva_pkg::OP_LOAD_WR;
	assign pos_raddr = AW'(corner_sel);
	assign sum_raddr = (mode_q == mva_pkg::MODE_READ) ? AW'(vi_q) : AW'(corner_sel);
	assign sum_we    = (cmd.op == mva_pkg::OP_LOAD_WR) || (cmd.op == mva_pkg::OP_SUM_WR);
	assign sum_waddr = (cmd.op == mva_pkg::OP_LOAD_WR) ? AW'(vi_q) : AW'(corner_sel);

	// accumulate one face normal into a corner record, or clear it on load
	assign cnt_rd   = sum_rdata[mva_pkg::REC_W-1 -: mva_pkg::CNT_W];
	assign cnt_zero = cnt_rd == '0;
	always_comb begin
		if (cmd.op == mva_pkg::OP_LOAD_WR) begin
			sum_wdata = '0;
		end else begin
			sum_wdata = {
				(cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1,
				sat_add(sum_rdata[2*mva_pkg::SUM_W +: mva_pkg::SUM_W], n_q[2]),
				sat_add(sum_rdata[mva_pkg::SUM_W +: mva_pkg::SUM_W], n_q[1]),
				sat_add(sum_rdata[0 +: mva_pkg::SUM_W], n_q[0])
			};
		end
	end

	mva_ram #(.WIDTH(POS3W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(vi_q)),
		.wdata ({pz_q, py_q, px_q}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	mva_ram #(.WIDTH(mva_pkg::REC_W), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// cross product operand selection, one product per step
	always_comb begin
		case (cmd.sel)
			3'd0:    begin mul_a = u_q[1]; mul_b = w_q[2]; end
			3'd1:    begin mul_a = u_q[2]; mul_b = w_q[1]; end
			3'd2:    begin mul_a = u_q[2]; mul_b = w_q[0]; end
			3'd3:    begin mul_a = u_q[0]; mul_b = w_q[2]; end
			3'd4:    begin mul_a = u_q[0]; mul_b = w_q[1]; end
			default: begin mul_a = u_q[1]; mul_b = w_q[0]; end
		endcase
	end
	assign prod = mul_a * mul_b;

	// vector entering the normalize unit: cross product or stored sum
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (mode_q == mva_pkg::MODE_READ) begin
				vec[j] = cnt_zero ? '0
					: mva_pkg::CR_W'(signed'(sum_rdata[j*mva_pkg::SUM_W +: mva_pkg::SUM_W]));
			end else begin
				vec[j] = cr_q[j];
			end
		end
	end

	// shared selection of one component
	assign mag_sel = mag_q[cmd.sel[1:0]];
	assign neg_sel = neg_q[cmd.sel[1:0]];
	assign sq      = mag_sel[mva_pkg::NRM_W-1:0] * mag_sel[mva_pkg::NRM_W-1:0];
	assign sq_try  = res_q + bit_q;

	// corner capture in the cycle after each position read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.op == mva_pkg::OP_POS_RD;
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_q <= cmd.sel[1:0];
		if (rd_pend_q) begin
			pos_q[rd_sel_q] <= pos_rdata;
		end
	end

	// operation decoder of the datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			mva_pkg::OP_LATCH: begin
				mode_q   <= mva_pkg::mode_t'(mode);
				vi_q     <= vertex_index;
				px_q     <= pos_x;
				py_q     <= pos_y;
				pz_q     <= pos_z;
				ca_q     <= corner_a;
				cb_q     <= corner_b;
				cc_q     <= corner_c;
				unused_q <= 1'b1;
				for (int j = 0; j < 3; j++) n_q[j] <= '0;
			end
			mva_pkg::OP_DIFF: begin
				for (int j = 0; j < 3; j++) begin
					u_q[j] <= mva_pkg::DIFF_W'(signed'(pos_q[1][j*mva_pkg::POS_W +: mva_pkg::POS_W]))
						- mva_pkg::DIFF_W'(signed'(pos_q[0][j*mva_pkg::POS_W +: mva_pkg::POS_W]));
					w_q[j] <= mva_pkg::DIFF_W'(signed'(pos_q[2][j*mva_pkg::POS_W +: mva_pkg::POS_W]))
						- mva_pkg::DIFF_W'(signed'(pos_q[0][j*mva_pkg::POS_W +: mva_pkg::POS_W]));
				end
			end
			mva_pkg::OP_MUL: begin
				if (!cmd.sel[0]) begin
					cr_q[cmd.sel[2:1]] <= mva_pkg::CR_W'(prod);
				end else begin
					cr_q[cmd.sel[2:1]] <= cr_q[cmd.sel[2:1]] - mva_pkg::CR_W'(prod);
				end
			end
			mva_pkg::OP_NINIT: begin
				for (int j = 0; j < 3; j++) begin
					mag_q[j] <= vec[j][mva_pkg::CR_W-1] ? mva_pkg::MAG_W'(-vec[j])
						: mva_pkg::MAG_W'(vec[j]);
					neg_q[j] <= vec[j][mva_pkg::CR_W-1];
					n_q[j]   <= '0;
				end
				if (mode_q == mva_pkg::MODE_READ) begin
					unused_q <= cnt_zero;
				end
			end
			mva_pkg::OP_SHIFT: begin
				for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
			end
			mva_pkg::OP_SQ: begin
				acc_q <= (cmd.sel[1:0] == 2'd0) ? mva_pkg::SQ_W'(sq) : acc_q + mva_pkg::SQ_W'(sq);
			end
			mva_pkg::OP_SQRT_INIT: begin
				x_q   <= acc_q;
				res_q <= '0;
				bit_q <= mva_pkg::SQ_W'(1) << (mva_pkg::SQ_W - 2);
			end
			mva_pkg::OP_SQRT_STEP: begin
				// one result bit per step
				if (x_q >= sq_try) begin
					x_q   <= x_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			mva_pkg::OP_DIV_INIT: begin
				// (m * 2^15 + L) / (2 * L), restoring, divisor pre-shifted
				rem_q <= mva_pkg::NUM_W'({mag_sel[mva_pkg::NRM_W-1:0], {mva_pkg::Q_W{1'b0}}})
					+ mva_pkg::NUM_W'(res_q[mva_pkg::LEN_W-1:0]);
				dsh_q <= mva_pkg::NUM_W'({res_q[mva_pkg::LEN_W-1:0], 1'b0}) << (mva_pkg::Q_W - 1);
				quo_q <= '0;
			end
			mva_pkg::OP_DIV_STEP: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[mva_pkg::Q_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[mva_pkg::Q_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			mva_pkg::OP_DIV_STORE: begin
				n_q[cmd.sel[1:0]] <= neg_sel ? -mva_pkg::N_W'(quo_q) : mva_pkg::N_W'(quo_q);
			end
			mva_pkg::OP_OUT: begin
				out_x_q      <= n_q[0];
				out_y_q      <= n_q[1];
				out_z_q      <= n_q[2];
				out_unused_q <= unused_q;
			end
			default: begin
			end
		endcase
	end

	assign normal_x      = out_x_q;
	assign normal_y      = out_y_q;
	assign normal_z      = out_z_q;
	assign unused_vertex = out_unused_q;

endmodule

// ----- design/mva_ctrl.sv -----
// Controller: sequences loads, triangle updates and normal reads over the datapath.
// Depends on mva_pkg.
module mva_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output mva_pkg::dp_cmd_t   cmd,
	input  mva_pkg::dp_stat_t  stat
);

	mva_pkg::ctrl_state_t state_q, state_d;
	logic [1:0]           idx_q, idx_d;
	logic [4:0]           cnt_q, cnt_d;
	logic                 out_valid_q;
	logic                 out_load;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mva_pkg::ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_load ? 1'b1 : (out_stall ? out_valid_q : 1'b0);
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		cmd.op   = mva_pkg::OP_NONE;
		cmd.sel  = {1'b0, idx_q};
		out_load = 1'b0;
		unique case (state_q)
			mva_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = mva_pkg::OP_LATCH;
					state_d = mva_pkg::ST_DISP;
				end
			end
			mva_pkg::ST_DISP: begin
				idx_d = '0;
				cnt_d = '0;
				unique case (stat.mode)
					mva_pkg::MODE_LOAD: state_d = stat.vi_ok ? mva_pkg::ST_LOAD : mva_pkg::ST_IDLE;
					mva_pkg::MODE_TRI:  state_d = stat.tri_ok ? mva_pkg::ST_POSRD : mva_pkg::ST_IDLE;
					mva_pkg::MODE_READ: state_d = stat.vi_ok ? mva_pkg::ST_SUMRD : mva_pkg::ST_DONE;
					default:            state_d = mva_pkg::ST_IDLE;
				endcase
			end
			mva_pkg::ST_LOAD: begin
				cmd.op  = mva_pkg::OP_LOAD_WR;
				state_d = mva_pkg::ST_IDLE;
			end
			mva_pkg::ST_POSRD: begin
				cmd.op = mva_pkg::OP_POS_RD;
				if (idx_q == 2'd2) begin
					state_d = mva_pkg::ST_POSW;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			mva_pkg::ST_POSW: begin
				state_d = mva_pkg::ST_DIFF;
			end
			mva_pkg::ST_DIFF: begin
				cmd.op  = mva_pkg::OP_DIFF;
				cnt_d   = '0;
				state_d = mva_pkg::ST_MUL;
			end
			mva_pkg::ST_MUL: begin
				cmd.op  = mva_pkg::OP_MUL;
				cmd.sel = cnt_q[2:0];
				if (cnt_q == 5'd5) begin
					state_d = mva_pkg::ST_NINIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			mva_pkg::ST_NINIT: begin
				cmd.op  = mva_pkg::OP_NINIT;
				state_d = mva_pkg::ST_NCHK;
			end
			mva_pkg::ST_NCHK: begin
				idx_d = '0;
				if (!stat.nz) begin
					state_d = (stat.mode == mva_pkg::MODE_TRI) ? mva_pkg::ST_SUMRD : mva_pkg::ST_DONE;
				end else if (stat.big) begin
					state_d = mva_pkg::ST_NSHIFT;
				end else begin
					state_d = mva_pkg::ST_SQ;
				end
			end
			mva_pkg::ST_NSHIFT: begin
				cmd.op  = mva_pkg::OP_SHIFT;
				state_d = mva_pkg::ST_NCHK;
			end
			mva_pkg::ST_SQ: begin
				cmd.op = mva_pkg::OP_SQ;
				if (idx_q == 2'd2) begin
					state_d = mva_pkg::ST_SQI;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			mva_pkg::ST_SQI: begin
				cmd.op  = mva_pkg::OP_SQRT_INIT;
				cnt_d   = '0;
				state_d = mva_pkg::ST_SQRT;
			end
			mva_pkg::ST_SQRT: begin
				cmd.op = mva_pkg::OP_SQRT_STEP;
				if (cnt_q == 5'(mva_pkg::SQRT_STEPS - 1)) begin
					idx_d   = '0;
					state_d = mva_pkg::ST_DINIT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			mva_pkg::ST_DINIT: begin
				cmd.op  = mva_pkg::OP_DIV_INIT;
				cnt_d   = '0;
				state_d = mva_pkg::ST_DSTEP;
			end
			mva_pkg::ST_DSTEP: begin
				cmd.op = mva_pkg::OP_DIV_STEP;
				if (cnt_q == 5'(mva_pkg::DIV_STEPS - 1)) begin
					state_d = mva_pkg::ST_DSTORE;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			mva_pkg::ST_DSTORE: begin
				cmd.op = mva_pkg::OP_DIV_STORE;
				if (idx_q == 2'd2) begin
					idx_d   = '0;
					state_d = (stat.mode == mva_pkg::MODE_TRI) ? mva_pkg::ST_SUMRD : mva_pkg::ST_DONE;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = mva_pkg::ST_DINIT;
				end
			end
			mva_pkg::ST_SUMRD: begin
				cmd.op  = mva_pkg::OP_SUM_RD;
				state_d = (stat.mode == mva_pkg::MODE_READ) ? mva_pkg::ST_NINIT : mva_pkg::ST_SUMWR;
			end
			mva_pkg::ST_SUMWR: begin
				cmd.op = mva_pkg::OP_SUM_WR;
				if (idx_q == 2'd2) begin
					state_d = mva_pkg::ST_IDLE;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = mva_pkg::ST_SUMRD;
				end
			end
			mva_pkg::ST_DONE: begin
				// hand the result over once the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.op   = mva_pkg::OP_OUT;
					out_load = 1'b1;
					state_d  = mva_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mva_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != mva_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ----- design/mva_checker.sv -----
// Port-level checker for the mesh vertex normal averager, bound to the top level.
// Depends on mesh_vertex_normal_averager_defines.svh.
`include "mesh_vertex_normal_averager_defines.svh"

module mva_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic              unused_vertex
);

	// a result waiting under stall stays offered
	`MVA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

	// a stalled result keeps its payload
	`MVA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(normal_x) && $stable(normal_y) && $stable(normal_z) && $stable(unused_vertex), "stalled result changed")

	// one request at a time: an accepted request blocks the next cycle
	`MVA_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "request taken while busy")

	// an unused vertex reports a zero normal
	`MVA_ASSERT_NOW(a_unused_zero, out_valid && unused_vertex, normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0, "unused vertex with nonzero normal")

endmodule

bind mesh_vertex_normal_averager mva_checker u_mva_checker (.*);

// ----- tb/sv/mesh_vertex_normal_averager_test.sv -----
// Self-checking bench for mesh_vertex_normal_averager: loads, triangles and normal reads.
// Depends on mva_pkg and the block; predicts per-vertex normal sums and checks every read.
module mesh_vertex_normal_averager_test;

	localparam int DEPTH = mva_pkg::VERTEX_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SUM_HI = 8388607;
	localparam int SUM_LO = -8388608;

	typedef struct {
		mva_pkg::mode_t     mode;
		logic [9:0]         vidx;
		logic signed [17:0] px, py, pz;
		logic [9:0]         ca, cb, cc;
	} request_t;

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic               unused;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [9:0] vertex_index = '0;
	logic signed [17:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [9:0] corner_a = '0, corner_b = '0, corner_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic unused_vertex;

	mesh_vertex_normal_averager u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted vertex state
	longint pos_mem [DEPTH][3];
	longint acc_mem [DEPTH][3];
	int     uses_mem [DEPTH];

	request_t pending_q[$];
	normal_t  expected_normals[$];
	int  errors = 0;
	int  reads_checked = 0;
	int  items_sent = 0;
	int  hold_until_drained = 0;

	function automatic longint isqrt(longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Unit vector in Q1.14 after right-shifting large magnitudes below 2^30
	function automatic void unit_q14(input longint v[3], output longint n[3]);
		longint unsigned mg[3];
		longint unsigned mx = 0, sq = 0, len, q;
		int k = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = v[i] < 0 ? -v[i] : v[i];
			if (mg[i] > mx) mx = mg[i];
			n[i] = 0;
		end
		if (mx == 0) return;
		while ((mx >> k) >= (64'd1 << 30)) k++;
		for (int i = 0; i < 3; i++) begin
			mg[i] >>= k;
			sq += mg[i] * mg[i];
		end
		len = isqrt(sq);
		if (len == 0) return;
		for (int i = 0; i < 3; i++) begin
			q = (mg[i] * 32768 + len) / (2 * len);
			if (q > 16384) q = 16384;
			n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic longint clamp_sum(longint s);
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	// Apply one accepted request to the predicted state
	function automatic void predict_request(request_t r);
		longint u[3], w[3], cr[3], fn[3], sn[3];
		int c[3];
		normal_t e;
		case (r.mode)
			mva_pkg::MODE_LOAD: begin
				pos_mem[r.vidx] = '{r.px, r.py, r.pz};
				acc_mem[r.vidx] = '{0, 0, 0};
				uses_mem[r.vidx] = 0;
			end
			mva_pkg::MODE_TRI: begin
				c = '{r.ca, r.cb, r.cc};
				for (int i = 0; i < 3; i++) begin
					u[i] = pos_mem[c[1]][i] - pos_mem[c[0]][i];
					w[i] = pos_mem[c[2]][i] - pos_mem[c[0]][i];
				end
				cr[0] = u[1] * w[2] - u[2] * w[1];
				cr[1] = u[2] * w[0] - u[0] * w[2];
				cr[2] = u[0] * w[1] - u[1] * w[0];
				unit_q14(cr, fn);
				for (int j = 0; j < 3; j++) begin
					for (int i = 0; i < 3; i++)
						acc_mem[c[j]][i] = clamp_sum(acc_mem[c[j]][i] + fn[i]);
					if (uses_mem[c[j]] < 255) uses_mem[c[j]]++;
				end
			end
			mva_pkg::MODE_READ: begin
				e = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
				if (uses_mem[r.vidx] != 0) begin
					unit_q14(acc_mem[r.vidx], sn);
					e = '{sn[0][15:0], sn[1][15:0], sn[2][15:0], 1'b0};
				end
				expected_normals = {expected_normals, e};
			end
			default: ;
		endcase
	endfunction

	// Driver: one request from the queue at a time, random gaps between them; random result waits
	int  gap = 0;
	bit  have_req = 0;
	bit  in_taken = 0;
	bit  out_taken = 0;
	int  out_wait = 0;
	request_t cur;
	always @(negedge clk) begin
		if (arst_n) begin
			// request accepted at the previous rising edge
			if (in_taken) begin
				in_taken = 0;
				have_req = 0;
			end
			if (!have_req) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (hold_until_drained > 0 && pending_q.size() > 0
						&& pending_q.size() == hold_until_drained
						&& expected_normals.size() != 0) begin
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur = pending_q.pop_front();
					have_req = 1;
					gap = $urandom_range(0, 9);
					if ($urandom_range(0, 3) == 0) gap = 0;
					in_valid <= 1'b1;
					mode <= cur.mode;
					vertex_index <= cur.vidx;
					pos_x <= cur.px;
					pos_y <= cur.py;
					pos_z <= cur.pz;
					corner_a <= cur.ca;
					corner_b <= cur.cb;
					corner_c <= cur.cc;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// result side: a fresh wait for every result
			if (out_taken) begin
				out_taken = 0;
				out_wait = $urandom_range(0, 9);
			end else if (out_valid && out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait != 0);
		end
	end

	// Monitor: predict on accepted requests, check accepted normals
	int idle_cycles = 0;
	always @(posedge clk) begin
		normal_t got, want;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				predict_request(cur);
				items_sent++;
				in_taken = 1;
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				out_taken = 1;
				got = '{normal_x, normal_y, normal_z, unused_vertex};
				if (expected_normals.size() == 0) begin
					errors++;
					$display("%0t: unexpected normal %0d %0d %0d unused %0b", $time,
						got.nx, got.ny, got.nz, got.unused);
				end else begin
					want = expected_normals.pop_front();
					reads_checked++;
					if (got.nx !== want.nx || got.ny !== want.ny
							|| got.nz !== want.nz || got.unused !== want.unused) begin
						errors++;
						$display("%0t: normal expected %0d %0d %0d u%0b got %0d %0d %0d u%0b",
							$time, want.nx, want.ny, want.nz, want.unused,
							got.nx, got.ny, got.nz, got.unused);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Stimulus builders
	bit live [DEPTH];
	int live_list[$];

	function automatic request_t blank_req(mva_pkg::mode_t m);
		request_t r;
		r.mode = m;
		r.vidx = 10'($urandom_range(0, 1023));
		r.px = 18'($urandom); r.py = 18'($urandom); r.pz = 18'($urandom);
		r.ca = 10'($urandom_range(0, 1023));
		r.cb = 10'($urandom_range(0, 1023));
		r.cc = 10'($urandom_range(0, 1023));
		return r;
	endfunction

	task automatic queue_load(int v, int x, int y, int z);
		request_t r = blank_req(mva_pkg::MODE_LOAD);
		r.vidx = 10'(v); r.px = 18'(x); r.py = 18'(y); r.pz = 18'(z);
		pending_q = {pending_q, r};
		if (!live[v]) live_list = {live_list, v};
		live[v] = 1;
	endtask

	task automatic queue_tri(int a, int b, int c);
		request_t r = blank_req(mva_pkg::MODE_TRI);
		r.ca = 10'(a); r.cb = 10'(b); r.cc = 10'(c);
		pending_q = {pending_q, r};
	endtask

	task automatic queue_read(int v);
		request_t r = blank_req(mva_pkg::MODE_READ);
		r.vidx = 10'(v);
		pending_q = {pending_q, r};
	endtask

	function automatic int pick_live();
		return live_list[$urandom_range(0, live_list.size() - 1)];
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 4) == 0 ? -131072 : 131071;
			1: return $signed($urandom_range(0, 2047)) - 1024;
			default: return $signed(18'($urandom));
		endcase
	endfunction

	initial begin
		int v, n;
		request_t r;
		// Directed: extremes, degenerate, repeated corner, unused, cancelled, nop
		queue_load(0, 0, 0, 0);
		queue_load(1, 131071, 0, 0);
		queue_load(2, 0, 131071, 0);
		queue_load(1023, -131072, -131072, 131071);
		queue_load(3, 0, 0, -131072);
		queue_read(0);                 // unused
		queue_tri(0, 1, 2);
		queue_tri(0, 2, 1);            // cancels sum at 0..2
		queue_read(0);                 // cancelled: zero, used
		queue_tri(1, 1, 2);            // repeated corner, degenerate
		queue_tri(1, 2, 1023);
		queue_tri(0, 3, 1023);
		queue_read(1);
		queue_read(1023);
		queue_read(3);
		r = blank_req(mva_pkg::MODE_NOP); pending_q = {pending_q, r};
		// Count saturation and +z sum saturation on vertex 4
		queue_load(4, 0, 0, 0);
		queue_load(5, 16384, 0, 0);
		queue_load(6, 0, 16384, 0);
		for (int i = 0; i < 520; i++) queue_tri(4, 5, 6);
		queue_read(4);
		hold_until_drained = pending_q.size();
		// Random part: meshes over a small live set, with loads re-clearing vertices
		for (int i = 0; i < 40; i++)
			queue_load($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
		n = 0;
		while (n < 640) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					v = ($urandom_range(0, 3) == 0) ? pick_live() : $urandom_range(0, 1023);
					queue_load(v, rand_coord(), rand_coord(), rand_coord());
				end
				2, 3, 4, 5: queue_tri(pick_live(), pick_live(), pick_live());
				6, 7, 8: queue_read(pick_live());
				default: begin
					r = blank_req(mva_pkg::MODE_NOP);
					pending_q = {pending_q, r};
				end
			endcase
			n++;
		end
		#14 arst_n = 1'b1;
		wait (pending_q.size() == 0 && !have_req);
		wait (expected_normals.size() == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d requests (loads, triangles, reads, no-ops); checked %0d normals.",
			items_sent, reads_checked);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+design
design/mva_pkg.sv
design/mva_ram.sv
design/mva_datapath.sv
design/mva_ctrl.sv
design/mesh_vertex_normal_averager.sv
design/mva_checker.sv
tb/sv/mesh_vertex_normal_averager_test.sv
